[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Needs a signal named clk and an active-low reset rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/spjq_pkg.sv]
// Package for the stable priority job queue: depth, field widths, codes, types.
// No dependencies; used by every module of the block by scoped names.
package spjq_pkg;

    localparam int DEPTH  = 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = 4;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_CLR = 2'd2,
        FUNC_NOP = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [16:0] time_in;
        logic [3:0]  priority_req;
        logic [15:0] doc_id;
        logic [7:0]  user_id;
    } job_t;

    typedef struct packed {
        status_t           status;
        job_t              job;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted input item
        logic exec;   // apply the operation and load the result register
    } cmd_t;

endpackage

[rtl/spjq_ctrl.sv]
// Controller of the stable priority job queue: accept, execute, deliver.
// Depends on spjq_pkg for the command struct.
module spjq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output spjq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance one step per operation, hold the result until it is taken
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Drive handshakes and datapath commands
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cmd.load  = in_valid && (state_reg == S_IDLE);
    assign cmd.exec  = (state_reg == S_EXEC);

endmodule

[rtl/spjq_datapath.sv]
// Datapath of the stable priority job queue: a row of sorted entry cells,
// the job count, the captured input item and the result register. Uses spjq_pkg.
module spjq_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spjq_pkg::cmd_t            cmd,
    input  logic [spjq_pkg::FUNC_W-1:0] func,
    input  spjq_pkg::job_t            job_in,
    output spjq_pkg::result_t         result
);

    spjq_pkg::job_t                  entry_reg [spjq_pkg::DEPTH];
    spjq_pkg::job_t                  entry_next [spjq_pkg::DEPTH];
    logic [spjq_pkg::CNT_W-1:0]      count_reg;
    logic [spjq_pkg::CNT_W-1:0]      count_next;
    logic [spjq_pkg::FUNC_W-1:0]     func_reg;
    spjq_pkg::job_t                  job_reg;
    spjq_pkg::result_t               result_reg;
    spjq_pkg::result_t               result_next;
    logic [spjq_pkg::DEPTH-1:0]      keep;
    logic                            full;
    logic                            empty;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            job_reg  <= job_in;
        end
    end

    assign full  = (count_reg == spjq_pkg::CNT_W'(spjq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // Cells at or above the new job's priority stay in place
    always_comb
    begin
        for (int i = 0; i < spjq_pkg::DEPTH; i++)
        begin
            keep[i] = (spjq_pkg::CNT_W'(i) < count_reg) &&
                      (entry_reg[i].priority_req >= job_reg.priority_req);
        end
    end

    // Next entries, count and result for the captured operation
    always_comb
    begin
        for (int i = 0; i < spjq_pkg::DEPTH; i++)
            entry_next[i] = entry_reg[i];
        count_next              = count_reg;
        result_next.status      = spjq_pkg::ST_OK;
        result_next.job         = '0;

        case (func_reg)
            spjq_pkg::FUNC_ENQ:
            begin
                if (full)
                begin
                    result_next.status = spjq_pkg::ST_FULL;
                end
                else
                begin
                    // Insert after the last kept cell, shift the rest down one
                    entry_next[0] = keep[0] ? entry_reg[0] : job_reg;
                    for (int i = 1; i < spjq_pkg::DEPTH; i++)
                    begin
                        if (keep[i])
                            entry_next[i] = entry_reg[i];
                        else if (keep[i-1])
                            entry_next[i] = job_reg;
                        else
                            entry_next[i] = entry_reg[i-1];
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            spjq_pkg::FUNC_DEQ:
            begin
                if (empty)
                begin
                    result_next.status = spjq_pkg::ST_EMPTY;
                end
                else
                begin
                    // Pop the head, shift every cell up one
                    result_next.status = spjq_pkg::ST_DEQ;
                    result_next.job    = entry_reg[0];
                    for (int i = 0; i < spjq_pkg::DEPTH - 1; i++)
                        entry_next[i] = entry_reg[i+1];
                    count_next = count_reg - 1'b1;
                end
            end
            spjq_pkg::FUNC_CLR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        result_next.occupancy = spjq_pkg::OCC_W'(count_next);
    end

    // Entry cells hold payload only
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < spjq_pkg::DEPTH; i++)
                entry_reg[i] <= entry_next[i];
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    assign result = result_reg;

endmodule

[rtl/stable_priority_job_queue.sv]
// Top level of the stable priority job queue: stream ports, controller, datapath.
// Depends on spjq_pkg, spjq_ctrl and spjq_datapath.
//
//  channel | direction | payload
//  s_*     | in        | tuser: func; tdata: user_id, doc_id, priority_req, time_in
//  m_*     | out       | tuser: status; tdata: out_user, out_doc, out_priority,
//          |           |        out_time_in, occupancy
//
// Each operation passes through capture, execution in the sorted cell row,
// and the output, where the result stays until it is taken.
// One operation is in flight at a time; s_tready is low from capture until
// the result transfer completes, so a stalled output holds the input off.
// Reset empties the queue; entry contents are not cleared.
module stable_priority_job_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // user_id[7:0], doc_id[23:8], priority_req[27:24],
                                   // time_in[44:28], zero pad[47:45]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_user[7:0], out_doc[23:8], out_priority[27:24],
                                   // out_time_in[44:28], occupancy[48:45], zero pad[55:49]
    output logic [1:0]  m_tuser    // status[1:0]
);

    spjq_pkg::cmd_t    cmd;
    spjq_pkg::job_t    job_in;
    spjq_pkg::result_t result;

    // Unpack the input item
    assign job_in.user_id      = s_tdata[7:0];
    assign job_in.doc_id       = s_tdata[23:8];
    assign job_in.priority_req = s_tdata[27:24];
    assign job_in.time_in      = s_tdata[44:28];

    spjq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    spjq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .func   (s_tuser),
        .job_in (job_in),
        .result (result)
    );

    // Pack the result item
    assign m_tuser = result.status;
    assign m_tdata = {7'd0, result.occupancy, result.job.time_in, result.job.priority_req,
                      result.job.doc_id, result.job.user_id};

endmodule

[rtl/spjq_checker.sv]
// Port-level checker for the stable priority job queue, bound to the top level.
// Depends on assert_macros.svh and spjq_pkg.
`include "assert_macros.svh"

module spjq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds still
    `AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // One operation in flight: never ready for input while a result is shown
    `AST_SAME(a_one_in_flight, 1'b1, !(s_tready && m_tvalid))

    // Job fields are zero unless a job was dequeued
    `AST_SAME(a_zero_fields, m_tvalid && (m_tuser != spjq_pkg::ST_DEQ), m_tdata[44:0] == 45'd0)

    // Occupancy never exceeds the depth
    `AST_SAME(a_occ_bound, m_tvalid && (spjq_pkg::DEPTH < 16), m_tdata[48:45] <= 4'(spjq_pkg::DEPTH))

endmodule

bind stable_priority_job_queue spjq_checker u_spjq_checker (.*);

[test/tb_stable_priority_job_queue.sv]
// Testbench for stable_priority_job_queue: directed and random enqueue, dequeue,
// clear and no-op transfers checked against a sorted job list kept in the bench.
// Depends on spjq_pkg and the stable_priority_job_queue RTL.
module tb_stable_priority_job_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spjq_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 95;

    // Sorted job list and the results it predicts, oldest first
    class job_order_tracker;
        job_t    stored_jobs [DEPTH];
        int      stored_count;
        result_t pending_results [$];
        int      mismatches;
        int      results_seen;
        int      enq_count;
        int      full_drops;
        int      deq_count;
        int      empty_hits;
        int      clr_count;
        int      nop_count;

        function new();
            stored_count = 0;
            mismatches   = 0;
            results_seen = 0;
            enq_count    = 0;
            full_drops   = 0;
            deq_count    = 0;
            empty_hits   = 0;
            clr_count    = 0;
            nop_count    = 0;
        endfunction

        // Apply one accepted operation and queue the result it must produce
        function void accept_op(func_t op, job_t nj);
            result_t r;
            int      pos;
            r        = '0;
            r.status = ST_OK;
            case (op)
                FUNC_ENQ:
                begin
                    enq_count++;
                    if (stored_count >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        full_drops++;
                    end
                    else
                    begin
                        // insert behind every job of equal or higher priority
                        pos = 0;
                        while (pos < stored_count &&
                               nj.priority_req <= stored_jobs[pos].priority_req)
                            pos++;
                        for (int i = stored_count; i > pos; i--)
                            stored_jobs[i] = stored_jobs[i-1];
                        stored_jobs[pos] = nj;
                        stored_count++;
                    end
                end
                FUNC_DEQ:
                begin
                    deq_count++;
                    if (stored_count == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_hits++;
                    end
                    else
                    begin
                        r.status = ST_DEQ;
                        r.job    = stored_jobs[0];
                        for (int i = 1; i < stored_count; i++)
                            stored_jobs[i-1] = stored_jobs[i];
                        stored_count--;
                    end
                end
                FUNC_CLR:
                begin
                    clr_count++;
                    stored_count = 0;
                end
                default:
                begin
                    nop_count++;
                end
            endcase
            r.occupancy = OCC_W'(stored_count);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string fname, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, fname, want, got);
            end
        endfunction

        // Match one result transfer against the oldest prediction
        function void check_result(status_t st, job_t jb, logic [OCC_W-1:0] occ);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with nothing outstanding, got status %0d occupancy %0d",
                         $time, st, occ);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status",       want.status,           st);
            compare_field("out_user",     want.job.user_id,      jb.user_id);
            compare_field("out_doc",      want.job.doc_id,       jb.doc_id);
            compare_field("out_priority", want.job.priority_req, jb.priority_req);
            compare_field("out_time_in",  want.job.time_in,      jb.time_in);
            compare_field("occupancy",    want.occupancy,        occ);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    job_order_tracker tracker = new();
    bit  no_idle      = 1'b0;
    bit  hold_off_req = 1'b0;
    int  idle_cycles  = 0;

    stable_priority_job_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic job_t make_job(logic [7:0] u, logic [15:0] d, logic [3:0] p,
                                      logic [16:0] t);
        job_t j;
        j.user_id      = u;
        j.doc_id       = d;
        j.priority_req = p;
        j.time_in      = t;
        return j;
    endfunction

    // Offer one operation after a random gap and hold it until the transfer
    task automatic send_op(func_t op, job_t jb);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, jb};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    // Record transfers on both sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_result(status_t'(m_tuser), job_t'(m_tdata[44:0]),
                                     m_tdata[48:45]);
            if (s_tvalid && s_tready)
                tracker.accept_op(func_t'(s_tuser), job_t'(s_tdata[44:0]));
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Reset, directed operations, then random phases
    initial
    begin
        job_t  jb;
        func_t op;
        int    pick;
        int    enq_weight;
        int    prio_hi;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_NOP;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dequeue on an empty queue
        send_op(FUNC_DEQ, '0);
        // fill with field extremes and priority ties
        send_op(FUNC_ENQ, make_job(8'h00, 16'h0000, 4'd0,  17'd0));
        send_op(FUNC_ENQ, make_job(8'hFF, 16'hFFFF, 4'd15, 17'd86399));
        send_op(FUNC_ENQ, make_job(8'h12, 16'h3456, 4'd7,  17'd1000));
        send_op(FUNC_ENQ, make_job(8'h34, 16'h789A, 4'd7,  17'd2000));
        send_op(FUNC_ENQ, make_job(8'h56, 16'hBCDE, 4'd15, 17'h1FFFF));
        send_op(FUNC_ENQ, make_job(8'hA5, 16'h5A5A, 4'd0,  17'd1));
        send_op(FUNC_ENQ, make_job(8'h5A, 16'hA5A5, 4'd7,  17'd3000));
        send_op(FUNC_ENQ, make_job(8'h81, 16'h8001, 4'd3,  17'h10000));
        // enqueue on a full queue is dropped
        send_op(FUNC_ENQ, make_job(8'h7E, 16'h7FFE, 4'd15, 17'd5));
        // unused code leaves the queue alone
        send_op(FUNC_NOP, make_job(8'hC3, 16'h3C3C, 4'hA, 17'h15555));
        // drain in priority order, then one past empty
        repeat (DEPTH + 1) send_op(FUNC_DEQ, '0);
        // clear a partly filled queue
        send_op(FUNC_ENQ, make_job(8'h01, 16'h0101, 4'd9, 17'd10));
        send_op(FUNC_ENQ, make_job(8'h02, 16'h0202, 4'd9, 17'd20));
        send_op(FUNC_CLR, make_job(8'hEE, 16'hEEEE, 4'd4, 17'd30));
        send_op(FUNC_DEQ, '0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            no_idle    = (ph % 4 == 3);
            enq_weight = (ph % 3 == 0) ? 75 : ((ph % 3 == 1) ? 50 : 30);
            prio_hi    = (ph % 2 == 1) ? 15 : 2;
            if (ph == 2)
                hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < enq_weight)
                    op = FUNC_ENQ;
                else if (pick < 94)
                    op = FUNC_DEQ;
                else if (pick < 97)
                    op = FUNC_CLR;
                else
                    op = FUNC_NOP;
                jb.user_id      = 8'($urandom);
                jb.doc_id       = 16'($urandom);
                jb.priority_req = 4'($urandom_range(0, prio_hi));
                if ($urandom_range(0, 9) == 0)
                    jb.time_in = 17'($urandom_range(86400, 131071));
                else
                    jb.time_in = 17'($urandom_range(0, 86399));
                send_op(op, jb);
            end
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        // drain outstanding results, then let the block settle
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d enqueues (%0d dropped on full), %0d dequeues (%0d on empty),",
                 tracker.enq_count, tracker.full_drops, tracker.deq_count,
                 tracker.empty_hits);
        $display("%0d clears and %0d no-ops; %0d results checked, %0d mismatches.",
                 tracker.clr_count, tracker.nop_count, tracker.results_seen,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
